// ===== rtl/ffha_pkg.sv =====
// ffha_pkg: command and status codes and the field width for the first-fit heap allocator.
// Depends on nothing; used by the allocator top level and its checker.
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int FIELD_W = 24;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_REALLOC = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NULL     = 2'd1;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd2;
    localparam logic [1:0] STATUS_INVALID  = 2'd3;

endpackage

// ===== rtl/first_fit_heap_allocator.sv =====
// first_fit_heap_allocator: first-fit heap block table with break pointer, no split or coalesce.
// Depends on ffha_pkg and ffha_ram (block table storage).
`timescale 1ns / 1ps
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------------
//  s_      | in        | s_valid / s_ready    | command, request_size, block_address
//  m_      | out       | m_valid / m_ready    | result_address, status, moved, copy_length
//  cfg_    | in        | cfg_wr_en (no wait)  | heap_limit
//
//  One command at a time: the table is scanned after accept, and the result is registered in the decide state.
//  s_ready returns with the result, or in the cycle after it when reallocate moves a block.
//  The table scan reads one entry per cycle from the single read port of the table RAM.
//  Reset clears the entry count, the break and the output valid; the table is not cleared.
//  s_ready is high only between commands; a command may be taken while a result waits,
//  and the next result is held back until m_ready drains the output register.

module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24,
    parameter int ADDRESS_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_wr_en,
    input  logic [ffha_pkg::FIELD_W-1:0] cfg_wr_data,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_command,
    input  logic [ffha_pkg::FIELD_W-1:0] s_request_size,
    input  logic [ffha_pkg::FIELD_W-1:0] s_block_address,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ffha_pkg::FIELD_W-1:0] m_result_address,
    output logic [1:0]                   m_status,
    output logic                         m_moved,
    output logic [ffha_pkg::FIELD_W-1:0] m_copy_length
);

    localparam int FW = ffha_pkg::FIELD_W;
    localparam int BW = (ADDRESS_BITS < FW) ? ADDRESS_BITS : FW;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int NW = FW + 2;
    localparam int EW = BW + FW + 1;
    localparam logic [63:0]   ADDR_MAX  = (64'd1 << ADDRESS_BITS) - 64'd1;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_BLOCKS);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_DECIDE  = 2'd2;
    localparam logic [1:0] ST_RELEASE = 2'd3;

    typedef struct packed {
        logic [BW-1:0] start;
        logic [FW-1:0] size;
        logic          free_mark;
    } entry_t;

    logic [1:0]    state_reg, state_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [FW-1:0] size_reg, size_next;
    logic [FW-1:0] addr_reg, addr_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] data_idx_reg, data_idx_next;
    logic          found_reg, found_next;
    logic [IW-1:0] find_idx_reg, find_idx_next;
    logic [FW-1:0] find_size_reg, find_size_next;
    logic          find_free_reg, find_free_next;
    logic          fit_found_reg, fit_found_next;
    logic [IW-1:0] fit_idx_reg, fit_idx_next;
    logic [BW-1:0] fit_start_reg, fit_start_next;
    logic [FW-1:0] fit_size_reg, fit_size_next;
    logic [CW-1:0] count_reg, count_next;
    logic [BW-1:0] break_reg, break_next;
    logic [FW-1:0] limit_reg, limit_next;
    logic          m_valid_reg, m_valid_next;
    logic [FW-1:0] res_addr_reg, res_addr_next;
    logic [1:0]    status_reg, status_next;
    logic          moved_reg, moved_next;
    logic [FW-1:0] copy_reg, copy_next;

    logic          ram_wr_en;
    logic [IW-1:0] ram_wr_addr;
    entry_t        ram_wr_data;
    logic          ram_rd_en;
    entry_t        ram_rd_data;

    logic          out_free;
    logic [NW-1:0] start_sum;
    logic [NW-1:0] next_break;
    logic          append_ok;
    logic          alloc_mode;
    logic          old_valid;

    ffha_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg[IW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_result_address = res_addr_reg;
    assign m_status         = status_reg;
    assign m_moved          = moved_reg;
    assign m_copy_length    = copy_reg;

    assign out_free   = !m_valid_reg || m_ready;
    assign ram_rd_en  = (state_reg == ST_SCAN) && (rd_ptr_reg < count_reg);
    assign start_sum  = NW'(break_reg) + NW'(HEADER_BYTES);
    assign next_break = start_sum + NW'(size_reg);
    assign append_ok  = (count_reg < MAX_COUNT) && !(next_break > NW'(limit_reg))
                        && !(64'(next_break) > ADDR_MAX);
    assign old_valid  = found_reg && !find_free_reg;
    assign alloc_mode = (cmd_reg == ffha_pkg::CMD_ALLOC)
                        || ((cmd_reg == ffha_pkg::CMD_REALLOC) && (addr_reg == '0))
                        || ((cmd_reg == ffha_pkg::CMD_REALLOC) && old_valid
                            && (find_size_reg < size_reg));

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        rd_ptr_next    = rd_ptr_reg;
        pend_next      = 1'b0;
        data_idx_next  = rd_ptr_reg[IW-1:0];
        found_next     = found_reg;
        find_idx_next  = find_idx_reg;
        find_size_next = find_size_reg;
        find_free_next = find_free_reg;
        fit_found_next = fit_found_reg;
        fit_idx_next   = fit_idx_reg;
        fit_start_next = fit_start_reg;
        fit_size_next  = fit_size_reg;
        count_next     = count_reg;
        break_next     = break_reg;
        limit_next     = cfg_wr_en ? cfg_wr_data : limit_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        res_addr_next  = res_addr_reg;
        status_next    = status_reg;
        moved_next     = moved_reg;
        copy_next      = copy_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = fit_idx_reg;
        ram_wr_data    = '{start: fit_start_reg, size: fit_size_reg, free_mark: 1'b0};

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next       = s_command;
                    size_next      = s_request_size;
                    addr_next      = s_block_address;
                    rd_ptr_next    = '0;
                    found_next     = 1'b0;
                    fit_found_next = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (ram_rd_en) begin
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                    pend_next   = 1'b1;
                end
                if (pend_reg) begin
                    if (FW'(ram_rd_data.start) == addr_reg) begin
                        found_next     = 1'b1;
                        find_idx_next  = data_idx_reg;
                        find_size_next = ram_rd_data.size;
                        find_free_next = ram_rd_data.free_mark;
                    end
                    if (!fit_found_reg && ram_rd_data.free_mark
                            && (ram_rd_data.size >= size_reg)) begin
                        fit_found_next = 1'b1;
                        fit_idx_next   = data_idx_reg;
                        fit_start_next = ram_rd_data.start;
                        fit_size_next  = ram_rd_data.size;
                    end
                end
                if (!ram_rd_en && !pend_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    res_addr_next = '0;
                    status_next   = ffha_pkg::STATUS_OK;
                    moved_next    = 1'b0;
                    copy_next     = '0;
                    state_next    = ST_IDLE;
                    if (alloc_mode) begin
                        if (size_reg == '0) begin
                            status_next = ffha_pkg::STATUS_NULL;
                        end else if (fit_found_reg) begin
                            ram_wr_en     = 1'b1;
                            res_addr_next = FW'(fit_start_reg);
                        end else if (append_ok) begin
                            ram_wr_en     = 1'b1;
                            ram_wr_addr   = count_reg[IW-1:0];
                            ram_wr_data   = '{start: start_sum[BW-1:0], size: size_reg,
                                              free_mark: 1'b0};
                            count_next    = count_reg + CW'(1);
                            break_next    = next_break[BW-1:0];
                            res_addr_next = FW'(start_sum[BW-1:0]);
                        end else begin
                            status_next = ffha_pkg::STATUS_NO_SPACE;
                        end
                        if ((cmd_reg == ffha_pkg::CMD_REALLOC) && (addr_reg != '0)
                                && (size_reg != '0) && (fit_found_reg || append_ok)) begin
                            moved_next = 1'b1;
                            copy_next  = find_size_reg;
                            state_next = ST_RELEASE;
                        end
                    end else begin
                        case (cmd_reg)
                            ffha_pkg::CMD_FREE: begin
                                if (addr_reg != '0) begin
                                    if (old_valid) begin
                                        ram_wr_en   = 1'b1;
                                        ram_wr_addr = find_idx_reg;
                                        ram_wr_data = '{start: addr_reg[BW-1:0],
                                                        size: find_size_reg,
                                                        free_mark: 1'b1};
                                    end else begin
                                        status_next = ffha_pkg::STATUS_INVALID;
                                    end
                                end
                            end
                            ffha_pkg::CMD_REALLOC: begin
                                if (old_valid) begin
                                    res_addr_next = addr_reg;
                                end else begin
                                    status_next = ffha_pkg::STATUS_INVALID;
                                end
                            end
                            default: begin
                                status_next = ffha_pkg::STATUS_OK;
                            end
                        endcase
                    end
                end
            end
            ST_RELEASE: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = find_idx_reg;
                ram_wr_data = '{start: addr_reg[BW-1:0], size: find_size_reg, free_mark: 1'b1};
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            break_reg   <= '0;
            limit_reg   <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            break_reg   <= break_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        size_reg      <= size_next;
        addr_reg      <= addr_next;
        rd_ptr_reg    <= rd_ptr_next;
        data_idx_reg  <= data_idx_next;
        found_reg     <= found_next;
        find_idx_reg  <= find_idx_next;
        find_size_reg <= find_size_next;
        find_free_reg <= find_free_next;
        fit_found_reg <= fit_found_next;
        fit_idx_reg   <= fit_idx_next;
        fit_start_reg <= fit_start_next;
        fit_size_reg  <= fit_size_next;
        res_addr_reg  <= res_addr_next;
        status_reg    <= status_next;
        moved_reg     <= moved_next;
        copy_reg      <= copy_next;
    end

endmodule

// ===== rtl/ffha_ram.sv =====
// ffha_ram: generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; holds the block table of the allocator.
`timescale 1ns / 1ps

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/ffha_checker.sv =====
// ffha_checker: port-level assertions for the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg for status codes.
`timescale 1ns / 1ps

module ffha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [23:0] m_result_address,
    input logic [1:0]  m_status,
    input logic        m_moved,
    input logic [23:0] m_copy_length
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_address) && $stable(m_status)
                                && $stable(m_moved) && $stable(m_copy_length))
        else $error("result word changed while stalled");

    a_fail_null: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ffha_pkg::STATUS_OK) |-> (m_result_address == '0) && !m_moved
                                                          && (m_copy_length == '0))
        else $error("failed command returned an address or a move");

    a_moved_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_moved |-> (m_status == ffha_pkg::STATUS_OK) && (m_copy_length != '0))
        else $error("move reported without success or copy length");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while a command is in progress");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_result_address (m_result_address),
    .m_status         (m_status),
    .m_moved          (m_moved),
    .m_copy_length    (m_copy_length)
);
